@@ rtl/lpf_pkg.sv @@
// shared constants and types for the longest palindrome finder
`default_nettype none
package lpf_pkg;
	localparam int MAX_LEN_DEF = 1024;

	// datapath commands from the controller
	typedef struct packed {
		logic load;     // store an incoming char
		logic init;     // clear search registers, i = 0
		logic seed;     // compute starting radius from mirror
		logic rd;       // char read request; not driven by the controller, reads run unconditionally
		logic cmp;      // extend the radius after a match or a non-character probe
		logic commit;   // write radius, update center/best, advance i
		logic clear;    // result taken: reset load counter and overflow flag
	} lpf_cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic can_ext;  // probe in range
		logic need_rd;  // probe is a character position
		logic match;    // compared chars equal
		logic done;     // i reached length
	} lpf_stat_t;
endpackage
`default_nettype wire

@@ rtl/lpf_ram.sv @@
// generic single-write, single-read ram with registered read
`default_nettype none
module lpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/lpf_datapath.sv @@
// datapath: string and radius stores, manacher registers, result
`default_nettype none
module lpf_datapath import lpf_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire lpf_cmd_t  cmd,
	input  wire logic [7:0] ch,
	output      lpf_stat_t stat,
	output      logic [9:0]  start_res,
	output      logic [10:0] length,
	output      logic        too_long
);
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = $clog2(MAX_LEN);
	localparam int PD = 2 * MAX_LEN + 1;
	localparam int PW = $clog2(PD + 1);
	localparam int RW = $clog2(PD);

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [PW-1:0] i_q, center_q, right_q, bcent_q, p_q, len_q;
	logic [PW-1:0] best_q;

	logic [7:0]    ca, cb;
	logic          cwe_a;
	logic [AW-1:0] raddr_a, raddr_b;
	logic [PW-1:0] rrdata;
	logic [RW-1:0] rraddr;

	// probe positions
	logic [PW:0] hi, lo;
	assign hi = {1'b0, i_q} + {1'b0, p_q} + 1'b1;
	assign lo = {1'b0, i_q} - {1'b0, p_q} - 1'b1;
	assign stat.can_ext = ({1'b0, i_q} >= {1'b0, p_q} + 1'b1) && (hi < {1'b0, len_q});
	assign stat.need_rd = hi[0];
	assign stat.match   = (ca == cb);
	assign stat.done    = (i_q >= len_q);

	assign cwe_a   = cmd.load && (count_q < CW'(MAX_LEN));
	assign raddr_a = AW'(hi[PW:1]);
	assign raddr_b = AW'(lo[PW:1]);

	lpf_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_chr_a (
		.clk(clk), .we(cwe_a), .waddr(AW'(count_q)), .wdata(ch),
		.raddr(raddr_a), .rdata(ca));
	lpf_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_chr_b (
		.clk(clk), .we(cwe_a), .waddr(AW'(count_q)), .wdata(ch),
		.raddr(raddr_b), .rdata(cb));

	// new center/right after commit
	logic [PW:0] reach;
	assign reach = {1'b0, i_q} + {1'b0, p_q};

	// mirror of next i about the center in force after this commit
	logic [PW:0]   twice_c, mirror, nxt_i;
	assign nxt_i   = cmd.init ? '0 : {1'b0, i_q} + 1'b1;
	assign twice_c = cmd.init ? '0 :
		(reach > {1'b0, right_q}) ? {i_q, 1'b0} : {center_q, 1'b0};
	assign mirror  = (twice_c >= nxt_i) ? twice_c - nxt_i : '0;
	assign rraddr  = RW'(mirror);

	lpf_ram #(.WIDTH(PW), .DEPTH(PD)) u_rad (
		.clk(clk), .we(cmd.commit), .waddr(RW'(i_q)), .wdata(p_q),
		.raddr(rraddr), .rdata(rrdata));
	logic mir_ok_q;

	// counters and manacher registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; ovf_q <= 1'b0; i_q <= '0; center_q <= '0;
			right_q <= '0; best_q <= '0; bcent_q <= '0; p_q <= '0;
			len_q <= '0; mir_ok_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (count_q < CW'(MAX_LEN)) count_q <= count_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (cmd.init) begin
				i_q <= '0; center_q <= '0; right_q <= '0;
				best_q <= '0; bcent_q <= '0;
				len_q <= PW'({count_q, 1'b1});
				mir_ok_q <= 1'b0;
			end
			if (cmd.seed) begin
				if (i_q < right_q) begin
					if (mir_ok_q && rrdata < right_q - i_q) p_q <= rrdata;
					else if (mir_ok_q) p_q <= right_q - i_q;
					else p_q <= '0;
				end else p_q <= '0;
			end
			if (cmd.cmp) p_q <= p_q + 1'b1;
			if (cmd.commit) begin
				i_q <= PW'(nxt_i);
				mir_ok_q <= mirror < nxt_i;
				if (reach > {1'b0, right_q}) begin
					center_q <= i_q; right_q <= PW'(reach);
				end
				if (p_q > best_q) begin
					best_q <= p_q; bcent_q <= i_q;
				end
			end
			if (cmd.clear) begin
				count_q <= '0; ovf_q <= 1'b0;
			end
		end
	end

	// result fields
	logic [PW-1:0] sdiff;
	assign sdiff     = (bcent_q >= best_q) ? bcent_q - best_q : '0;
	assign start_res = 10'(sdiff >> 1);
	assign length    = 11'(best_q);
	assign too_long  = ovf_q;
endmodule
`default_nettype wire

@@ rtl/lpf_ctrl.sv @@
// controller: load, manacher sequencing and result handoff
`default_nettype none
module lpf_ctrl import lpf_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_fire,
	input  wire logic      in_last,
	input  wire lpf_stat_t stat,
	input  wire logic      out_ready,
	output      logic      in_ready,
	output      logic      out_valid,
	output      lpf_cmd_t  cmd
);
	typedef enum logic [6:0] {
		S_LOAD = 7'b0000001, S_INIT = 7'b0000010, S_SEED = 7'b0000100,
		S_PROBE = 7'b0001000, S_CMP = 7'b0010000, S_COMMIT = 7'b0100000,
		S_OUT = 7'b1000000
	} state_t;
	state_t state_q, state_d;

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_OUT);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_LOAD: begin
				cmd.load = in_fire;
				if (in_fire && in_last) state_d = S_INIT;
			end
			S_INIT: begin
				cmd.init = 1'b1; state_d = S_SEED;
			end
			S_SEED: begin
				if (stat.done) state_d = S_OUT;
				else begin
					cmd.seed = 1'b1; state_d = S_PROBE;
				end
			end
			S_PROBE: begin
				if (!stat.can_ext) state_d = S_COMMIT;
				else if (!stat.need_rd) cmd.cmp = 1'b1;
				else state_d = S_CMP;
			end
			S_CMP: begin
				if (stat.match) begin
					cmd.cmp = 1'b1; state_d = S_PROBE;
				end else state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1; state_d = S_SEED;
			end
			S_OUT: begin
				if (out_ready) begin
					cmd.clear = 1'b1; state_d = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_LOAD;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

@@ rtl/longest_palindrome_finder.sv @@
// Usage: bytes enter on s_axis, one per item; s_axis_tlast marks the last
// byte and starts the search. One result item leaves on m_axis after the
// search: start offset, length and truncation flag of the longest
// palindromic substring, leftmost on ties.
// Loading accepts one byte per cycle while s_axis_tready is high. After the
// last byte, s_axis_tready drops; the search walks 2n+1 positions, each
// passing through seed, probe and commit states plus a probe step per radius
// extension, with a compare state for steps that read the character stores.
// Bytes past MAX_LEN are dropped and flagged in the result.
// The result holds on m_axis until m_axis_tready; then the block returns
// to loading a fresh string. Reset clears all control state; the stores
// need no clearing since entries are written before they are read.
`default_nettype none
module longest_palindrome_finder import lpf_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // ch
	input  wire logic        s_axis_tlast,
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [23:0] m_axis_tdata    // start_res, length, too_long, zero pad
);
	lpf_cmd_t  cmd;
	lpf_stat_t stat;
	logic [9:0]  start_res;
	logic [10:0] length;
	logic        too_long;
	logic        in_fire;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	lpf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_last(s_axis_tlast),
		.stat(stat), .out_ready(m_axis_tready), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .cmd(cmd));

	lpf_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .ch(s_axis_tdata), .stat(stat),
		.start_res(start_res), .length(length), .too_long(too_long));

	assign m_axis_tdata = {2'b00, too_long, length, start_res};

`ifndef SYNTHESIS
	// no input taken while a result waits
	a_no_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("in and out overlap");
	// result item leaves the output once taken
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
		else $error("result repeated");
	// length never exceeds max length
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> 32'(length) <= MAX_LEN) else $error("length too big");
`endif
endmodule
`default_nettype wire
